// File: hdl/ttm_pkg.sv
// Shared types and constants for the thermistor temperature monitor.
// Used by ttm_ctrl, ttm_dp and the top level; no dependencies.
`default_nettype none
package ttm_pkg;

  localparam logic [23:0] LN2_Q24     = 24'd11629080;
  localparam logic [14:0] T0_CK       = 15'd29815;
  localparam logic [13:0] HALF_ZERO_C = 14'd5463;
  localparam logic [22:0] BETA_SCALE  = 23'd6553600;
  localparam logic [35:0] NUM_SCALE   = 36'd39079116800;

  localparam logic [13:0] BETA_RESET = 14'd3435;
  localparam logic [11:0] FS_RESET   = 12'd4095;

  localparam logic REG_BETA = 1'b0;
  localparam logic REG_FS   = 1'b1;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_SHORT = 2'd1;
  localparam logic [1:0] FAULT_OPEN  = 2'd2;
  localparam logic [1:0] FAULT_NEVER = 2'd3;

  localparam int LOG_STEPS = 16;
  localparam int DIV_STEPS = 56;

  typedef struct packed {
    logic capture;
    logic log_load;
    logic log_sel;
    logic log_step;
    logic k_calc;
    logic prod1;
    logic prod2;
    logic den_calc;
    logic num1;
    logic num2;
    logic div_load_t;
    logic div_load_a;
    logic div_step;
    logic fin;
    logic upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic conv;
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/ttm_ctrl.sv
// Sequencing state machine for the thermistor temperature monitor.
// Depends on ttm_pkg (cmd_t, sts_t, step counts).
`default_nettype none
module ttm_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  input  ttm_pkg::sts_t  sts_i,
  output ttm_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOADA, S_LOGA, S_LOADB, S_LOGB, S_KMUL, S_PROD1, S_PROD2,
    S_DEN, S_NUM1, S_NUM2, S_DIVLT, S_DIVT, S_FIN, S_UPD, S_DIVLA,
    S_DIVA, S_OUT
  } state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  logic       out_valid_q;
  logic       out_free;
  logic       accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = accept;
    cmd_o.log_load   = (state_q == S_LOADA) || (state_q == S_LOADB);
    cmd_o.log_sel    = (state_q == S_LOADB);
    cmd_o.log_step   = (state_q == S_LOGA) || (state_q == S_LOGB);
    cmd_o.k_calc     = (state_q == S_KMUL);
    cmd_o.prod1      = (state_q == S_PROD1);
    cmd_o.prod2      = (state_q == S_PROD2);
    cmd_o.den_calc   = (state_q == S_DEN);
    cmd_o.num1       = (state_q == S_NUM1);
    cmd_o.num2       = (state_q == S_NUM2);
    cmd_o.div_load_t = (state_q == S_DIVLT);
    cmd_o.div_load_a = (state_q == S_DIVLA);
    cmd_o.div_step   = (state_q == S_DIVT) || (state_q == S_DIVA);
    cmd_o.fin        = (state_q == S_FIN);
    cmd_o.upd        = (state_q == S_UPD);
    cmd_o.out_load   = (state_q == S_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.conv ? S_LOADA : S_UPD;
          end
        end
        S_LOADA: begin
          cnt_q   <= '0;
          state_q <= S_LOGA;
        end
        S_LOGA: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(ttm_pkg::LOG_STEPS - 1)) begin
            state_q <= S_LOADB;
          end
        end
        S_LOADB: begin
          cnt_q   <= '0;
          state_q <= S_LOGB;
        end
        S_LOGB: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(ttm_pkg::LOG_STEPS - 1)) begin
            state_q <= S_KMUL;
          end
        end
        S_KMUL:  state_q <= S_PROD1;
        S_PROD1: state_q <= S_PROD2;
        S_PROD2: state_q <= S_DEN;
        S_DEN:   state_q <= S_NUM1;
        S_NUM1:  state_q <= S_NUM2;
        S_NUM2:  state_q <= S_DIVLT;
        S_DIVLT: begin
          cnt_q   <= '0;
          state_q <= S_DIVT;
        end
        S_DIVT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(ttm_pkg::DIV_STEPS - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: state_q <= S_UPD;
        S_UPD: state_q <= S_DIVLA;
        S_DIVLA: begin
          cnt_q   <= '0;
          state_q <= S_DIVA;
        end
        S_DIVA: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(ttm_pkg::DIV_STEPS - 1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/ttm_dp.sv
// Datapath: config registers, log2 unit, multipliers, restoring divider,
// per-sensor store and output register. Depends on ttm_pkg.
`default_nettype none
module ttm_dp #(
  parameter int SENSORS = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  input  wire                 cfg_index_i,
  input  wire  [13:0]         cfg_data_i,
  input  wire  [2:0]          sensor_index_i,
  input  wire  [11:0]         adc_raw_i,
  input  ttm_pkg::cmd_t       cmd_i,
  output ttm_pkg::sts_t       sts_o,
  output logic [2:0]          sensor_slot_o,
  output logic [1:0]          fault_code_o,
  output logic signed [15:0]  temperature_dc_o,
  output logic signed [15:0]  average_dc_o,
  output logic [3:0]          good_count_o
);

  localparam int IW    = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int CW    = $clog2(SENSORS + 1);
  localparam int SUM_W = 17 + $clog2(SENSORS);

  // configuration
  logic [13:0] beta_q;
  logic [11:0] fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= ttm_pkg::BETA_RESET;
      fs_q   <= ttm_pkg::FS_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ttm_pkg::REG_BETA) begin
        beta_q <= cfg_data_i;
      end else begin
        fs_q <= cfg_data_i[11:0];
      end
    end
  end

  // capture and classification
  logic [2:0]  idx_q;
  logic [11:0] adc_q;
  logic [1:0]  fault_q;
  logic        inr_q;
  logic [1:0]  fault_c;
  logic        inr_c;

  always_comb begin
    if (adc_raw_i == 12'd0) begin
      fault_c = ttm_pkg::FAULT_SHORT;
    end else if (adc_raw_i >= fs_q) begin
      fault_c = ttm_pkg::FAULT_OPEN;
    end else begin
      fault_c = ttm_pkg::FAULT_NONE;
    end
    inr_c = ({29'd0, sensor_index_i} < 32'(SENSORS));
  end

  assign sts_o.conv = inr_c && (fault_c == ttm_pkg::FAULT_NONE);

  // log2 unit
  logic [11:0] log_arg;
  logic [3:0]  norm_n;
  logic [30:0] m_q;
  logic [3:0]  n_q;
  logic [15:0] frac_q;
  logic [19:0] la_q;
  logic [61:0] sq_full;
  logic [31:0] sq;

  assign log_arg = cmd_i.log_sel ? (fs_q - adc_q) : adc_q;

  always_comb begin
    norm_n = '0;
    for (int i = 0; i < 12; i++) begin
      if (log_arg[i]) begin
        norm_n = 4'(i);
      end
    end
  end

  assign sq_full = m_q * m_q;
  assign sq      = sq_full[61:30];

  // conversion arithmetic
  logic signed [20:0] d_c;
  logic [19:0]        dmag_c;
  logic [34:0]        k_q;
  logic               kneg_q;
  logic [58:0]        acc_q;
  logic [49:0]        a_q;
  logic [36:0]        bprod_q;
  logic signed [39:0] den_q;
  logic signed [55:0] b_q;
  logic               den_pos_q;
  logic signed [55:0] nn_q;
  logic [41:0]        dd_q;
  logic [34:0]        term_c;
  logic signed [55:0] num_c;

  assign d_c    = $signed({1'b0, la_q}) - $signed({1'b0, n_q, frac_q});
  assign dmag_c = d_c[20] ? 20'(-d_c) : d_c[19:0];
  assign term_c = acc_q[58:24];
  assign num_c  = $signed({6'd0, a_q}) - b_q;

  // divider
  logic [55:0] quo_q;
  logic [41:0] rem_q;
  logic [41:0] dsr_q;
  logic        qneg_q;
  logic [42:0] trial;
  logic        ge;
  logic [55:0] nmag_c;

  assign trial  = {rem_q, quo_q[55]};
  assign ge     = (trial >= {1'b0, dsr_q});
  assign nmag_c = nn_q[55] ? 56'(-nn_q) : 56'(nn_q);

  // per-sensor store
  logic signed [15:0]      temps_q [SENSORS];
  logic [1:0]              faults_q [SENSORS];
  logic signed [SUM_W-1:0] sum_q;
  logic [CW-1:0]           cnt_q;
  logic signed [15:0]      temp_q;
  logic [IW-1:0]           ai;
  logic                    old_good;
  logic                    new_good;
  logic [SUM_W-1:0]        smag_c;
  logic [56:0]             qq_c;
  logic signed [15:0]      fin_c;
  logic signed [15:0]      avg_c;

  assign ai       = IW'(idx_q);
  assign old_good = (faults_q[ai] == ttm_pkg::FAULT_NONE);
  assign new_good = (fault_q == ttm_pkg::FAULT_NONE);
  assign smag_c   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign qq_c     = {1'b0, quo_q} + {56'd0, (rem_q != 42'd0)};

  always_comb begin
    if (!den_pos_q) begin
      fin_c = 16'sd32767;
    end else if (qneg_q) begin
      fin_c = (qq_c > 57'd32768) ? -16'sd32768 : 16'(-qq_c[15:0]);
    end else begin
      fin_c = (quo_q > 56'd32767) ? 16'sd32767 : $signed(quo_q[15:0]);
    end
    if (cnt_q == '0) begin
      avg_c = -16'sd32768;
    end else begin
      avg_c = qneg_q ? 16'(-quo_q[15:0]) : $signed(quo_q[15:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SENSORS; i++) begin
        temps_q[i]  <= '0;
        faults_q[i] <= ttm_pkg::FAULT_NEVER;
      end
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.upd && inr_q) begin
      temps_q[ai]  <= temp_q;
      faults_q[ai] <= fault_q;
      sum_q <= sum_q - (old_good ? SUM_W'(temps_q[ai]) : SUM_W'(0))
                     + (new_good ? SUM_W'(temp_q) : SUM_W'(0));
      cnt_q <= cnt_q - (old_good ? CW'(1) : CW'(0)) + (new_good ? CW'(1) : CW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q   <= sensor_index_i;
      adc_q   <= adc_raw_i;
      inr_q   <= inr_c;
      fault_q <= inr_c ? fault_c : ttm_pkg::FAULT_OPEN;
      temp_q  <= '0;
    end
    if (cmd_i.log_load) begin
      if (cmd_i.log_sel) begin
        la_q <= {n_q, frac_q};
      end
      n_q    <= norm_n;
      m_q    <= 31'({19'd0, log_arg} << (5'd30 - {1'b0, norm_n}));
      frac_q <= '0;
    end
    if (cmd_i.log_step) begin
      m_q    <= sq[31] ? sq[31:1] : sq[30:0];
      frac_q <= {frac_q[14:0], sq[31]};
    end
    if (cmd_i.k_calc) begin
      k_q    <= 35'(dmag_c * ttm_pkg::T0_CK);
      kneg_q <= d_c[20];
    end
    if (cmd_i.prod1) begin
      acc_q   <= 59'(k_q[17:0] * ttm_pkg::LN2_Q24);
      a_q     <= 50'(beta_q * ttm_pkg::NUM_SCALE);
      bprod_q <= 37'(beta_q * ttm_pkg::BETA_SCALE);
    end
    if (cmd_i.prod2) begin
      acc_q <= acc_q + {41'(k_q[34:18] * ttm_pkg::LN2_Q24), 18'd0};
    end
    if (cmd_i.den_calc) begin
      den_q <= $signed({3'd0, bprod_q})
             + (kneg_q ? -$signed({5'd0, term_c}) : $signed({5'd0, term_c}));
    end
    if (cmd_i.num1) begin
      b_q       <= 56'(56'(den_q) * $signed({42'd0, ttm_pkg::HALF_ZERO_C}));
      den_pos_q <= (den_q > 40'sd0);
    end
    if (cmd_i.num2) begin
      nn_q <= (num_c <<< 1) + (56'(den_q) <<< 1);
      dd_q <= {den_q, 2'b00};
    end
    if (cmd_i.div_load_t) begin
      quo_q  <= nmag_c;
      rem_q  <= '0;
      dsr_q  <= dd_q;
      qneg_q <= nn_q[55];
    end
    if (cmd_i.div_load_a) begin
      quo_q  <= 56'(smag_c);
      rem_q  <= '0;
      dsr_q  <= 42'(cnt_q);
      qneg_q <= sum_q[SUM_W-1];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? 42'(trial - {1'b0, dsr_q}) : trial[41:0];
      quo_q <= {quo_q[54:0], ge};
    end
    if (cmd_i.fin) begin
      temp_q <= fin_c;
    end
    if (cmd_i.out_load) begin
      sensor_slot_o    <= idx_q;
      fault_code_o     <= fault_q;
      temperature_dc_o <= temp_q;
      average_dc_o     <= avg_c;
      good_count_o     <= 4'(cnt_q);
    end
  end

endmodule
`default_nettype wire

// File: hdl/thermistor_temperature_monitor.sv
// Thermistor temperature monitor: one ADC sample in, one temperature and
// running average out. Top level; instantiates ttm_ctrl and ttm_dp.
//
// Input channel: in_valid_i / in_stall_o with sensor_index_i, adc_raw_i.
// A transaction is taken at an edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with slot, fault code,
// temperature, average and good count, held while stalled.
// Config channel: cfg_valid_i / cfg_ready_o, index 0 beta, 1 full scale.
// One item at a time. From acceptance to out_valid_o a good sample goes
// through two 16-step log2 runs, six arithmetic steps and two passes
// of the 56-step restoring divider (temperature, then average).
// A faulted sample skips the conversion and runs only the average pass.
// The output register lets the next item be accepted while a result
// still waits; if it is still full at completion the block holds.
// Reset: all sensors never read, sum and count zero, beta 3435,
// full scale 4095, output empty.
`default_nettype none
module thermistor_temperature_monitor #(
  parameter int SENSORS = 8
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire                cfg_index_i,
  input  wire  [13:0]        cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [2:0]         sensor_index_i,
  input  wire  [11:0]        adc_raw_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [2:0]         sensor_slot_o,
  output logic [1:0]         fault_code_o,
  output logic signed [15:0] temperature_dc_o,
  output logic signed [15:0] average_dc_o,
  output logic [3:0]         good_count_o
);

  ttm_pkg::cmd_t cmd;
  ttm_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ttm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ttm_dp #(
    .SENSORS (SENSORS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sensor_index_i   (sensor_index_i),
    .adc_raw_i        (adc_raw_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sensor_slot_o    (sensor_slot_o),
    .fault_code_o     (fault_code_o),
    .temperature_dc_o (temperature_dc_o),
    .average_dc_o     (average_dc_o),
    .good_count_o     (good_count_o)
  );

endmodule
`default_nettype wire

// File: tb/thermistor_temperature_monitor_tb.sv
// Self-checking testbench for thermistor_temperature_monitor: directed table, then random
// samples over several beta / full-scale settings, scored against a beta-equation predictor.
// Depends on ttm_pkg and the RTL of the block only.
`timescale 1ns / 100ps
`default_nettype none
module thermistor_temperature_monitor_tb;

  localparam int NSENS      = 8;
  localparam int CYCLE_CAP  = 3000000;
  localparam int PHASE_ITEMS = 200;

  typedef struct {
    logic [2:0]         slot;
    logic [1:0]         fault;
    logic signed [15:0] temp;
    logic signed [15:0] avg;
    logic [3:0]         cnt;
  } reading_t;

  typedef struct {
    logic [2:0]         idx;
    logic [11:0]        adc;
    bit                 typed;
    logic [1:0]         fault;
    logic signed [15:0] temp;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [13:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         sensor_index_i = '0;
  logic [11:0]        adc_raw_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         sensor_slot_o;
  logic [1:0]         fault_code_o;
  logic signed [15:0] temperature_dc_o;
  logic signed [15:0] average_dc_o;
  logic [3:0]         good_count_o;

  thermistor_temperature_monitor #(.SENSORS(NSENS)) i_dut (.*);

  reading_t    pending_readings[$];
  int          errors = 0;
  int          cyc = 0;
  bit          quiet_sender = 0;

  int unsigned beta_q = ttm_pkg::BETA_RESET;
  int unsigned fs_q   = ttm_pkg::FS_RESET;
  int          sens_temp[NSENS];
  logic [1:0]  sens_fault[NSENS];
  int          good_sum_q = 0;
  int          good_tot_q = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint log2_q16(int unsigned v);
    int unsigned       n;
    longint unsigned   m;
    int unsigned       frac;
    n = 0;
    frac = 0;
    while (n < 11 && (v >> (n + 1)) != 0) n++;
    m = longint'(v) << (30 - n);
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac |= (1 << b);
      end
    end
    return (longint'(n) << 16) | longint'(frac);
  endfunction

  function automatic int beta_temp_dc(int unsigned adc);
    longint d, k, mag, term, den, num, a, q;
    d = log2_q16(adc) - log2_q16(fs_q - adc);
    k = longint'(ttm_pkg::T0_CK) * d;
    mag = (k < 0) ? -k : k;
    term = (mag * longint'(ttm_pkg::LN2_Q24)) >>> 24;
    if (k < 0) term = -term;
    den = longint'(beta_q) * 64'sd6553600 + term;
    if (den <= 0) return 32767;
    num = 64'sd20 * longint'(ttm_pkg::T0_CK) * 64'sd65536 * longint'(beta_q)
          - longint'(ttm_pkg::HALF_ZERO_C) * den;
    a = 2 * num + 2 * den;
    q = a / (4 * den);
    if ((a % (4 * den)) != 0 && a < 0) q--;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic reading_t update_readings(logic [2:0] idx, logic [11:0] adc);
    reading_t r;
    int       t;
    logic [1:0] f;
    t = 0;
    if (adc == 0) f = ttm_pkg::FAULT_SHORT;
    else if (adc >= fs_q) f = ttm_pkg::FAULT_OPEN;
    else f = ttm_pkg::FAULT_NONE;
    if (f == ttm_pkg::FAULT_NONE) t = beta_temp_dc(adc);
    if (sens_fault[idx] == ttm_pkg::FAULT_NONE) begin
      good_sum_q -= sens_temp[idx];
      good_tot_q--;
    end
    sens_temp[idx] = t;
    sens_fault[idx] = f;
    if (f == ttm_pkg::FAULT_NONE) begin
      good_sum_q += t;
      good_tot_q++;
    end
    r.slot  = idx;
    r.fault = f;
    r.temp  = t[15:0];
    r.avg   = (good_tot_q > 0) ? 16'(good_sum_q / good_tot_q) : 16'h8000;
    r.cnt   = good_tot_q[3:0];
    return r;
  endfunction

  task automatic send_sample(logic [2:0] idx, logic [11:0] adc, bit typed,
                             logic [1:0] tf, logic signed [15:0] tt);
    reading_t r;
    in_valid_i     <= 1'b1;
    sensor_index_i <= idx;
    adc_raw_i      <= adc;
    do @(posedge clk_i); while (in_stall_o);
    r = update_readings(idx, adc);
    if (typed) begin
      r.fault = tf;
      r.temp  = tt;
    end
    pending_readings.push_back(r);
    if (!quiet_sender && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [13:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == ttm_pkg::REG_BETA) beta_q = data;
    else fs_q = data[11:0];
    @(posedge clk_i);
  endtask

  // receiver back-pressure: random, a long hold-off, then a clean stretch
  initial begin
    int n;
    n = 0;
    forever begin
      @(posedge clk_i);
      n++;
      if (n >= 20000 && n < 23000) out_stall_i <= 1'b1;
      else if (n >= 60000 && n < 90000) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(99) < 11);
    end
  end

  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $display("%0t unexpected transaction slot %0d", $time, sensor_slot_o);
        errors++;
      end else begin
        e = pending_readings.pop_front();
        if (sensor_slot_o !== e.slot) begin
          $display("%0t slot exp %0d got %0d", $time, e.slot, sensor_slot_o); errors++;
        end
        if (fault_code_o !== e.fault) begin
          $display("%0t fault exp %0d got %0d", $time, e.fault, fault_code_o); errors++;
        end
        if (temperature_dc_o !== e.temp) begin
          $display("%0t temp exp %0d got %0d", $time, e.temp, temperature_dc_o); errors++;
        end
        if (average_dc_o !== e.avg) begin
          $display("%0t avg exp %0d got %0d", $time, e.avg, average_dc_o); errors++;
        end
        if (good_count_o !== e.cnt) begin
          $display("%0t count exp %0d got %0d", $time, e.cnt, good_count_o); errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t   rows[$];
    logic [13:0] betas[8];
    logic [11:0] fss[8];
    int unsigned adc, pick;
    for (int i = 0; i < NSENS; i++) begin
      sens_temp[i] = 0;
      sens_fault[i] = ttm_pkg::FAULT_NEVER;
    end
    rows = '{
      '{3'd0, 12'd0,    1, ttm_pkg::FAULT_SHORT, 16'sd0},
      '{3'd1, 12'd4095, 1, ttm_pkg::FAULT_OPEN,  16'sd0},
      '{3'd2, 12'd1,    0, ttm_pkg::FAULT_NONE,  16'sd0},
      '{3'd3, 12'd4094, 0, ttm_pkg::FAULT_NONE,  16'sd0},
      '{3'd4, 12'd2047, 0, ttm_pkg::FAULT_NONE,  16'sd0},
      '{3'd5, 12'd1000, 0, ttm_pkg::FAULT_NONE,  16'sd0},
      '{3'd6, 12'd3000, 0, ttm_pkg::FAULT_NONE,  16'sd0},
      '{3'd7, 12'd2048, 0, ttm_pkg::FAULT_NONE,  16'sd0},
      '{3'd0, 12'd2500, 0, ttm_pkg::FAULT_NONE,  16'sd0},
      '{3'd2, 12'd0,    1, ttm_pkg::FAULT_SHORT, 16'sd0},
      '{3'd3, 12'd4095, 1, ttm_pkg::FAULT_OPEN,  16'sd0},
      '{3'd7, 12'd2730, 0, ttm_pkg::FAULT_NONE,  16'sd0}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_sample(rows[i].idx, rows[i].adc, rows[i].typed,
                                  rows[i].fault, rows[i].temp);
    drain_outputs();
    // small beta: a very low ADC reading drives the denominator negative
    write_reg(ttm_pkg::REG_BETA, 14'd1000);
    send_sample(3'd1, 12'd1, 0, ttm_pkg::FAULT_NONE, 16'sd0);
    send_sample(3'd4, 12'd4094, 0, ttm_pkg::FAULT_NONE, 16'sd0);
    drain_outputs();
    write_reg(ttm_pkg::REG_FS, 14'd1);
    send_sample(3'd5, 12'd1, 1, ttm_pkg::FAULT_OPEN, 16'sd0);
    send_sample(3'd6, 12'd0, 1, ttm_pkg::FAULT_SHORT, 16'sd0);
    drain_outputs();
    write_reg(ttm_pkg::REG_BETA, 14'd10000);
    write_reg(ttm_pkg::REG_FS, 14'd4095);
    send_sample(3'd0, 12'd3, 0, ttm_pkg::FAULT_NONE, 16'sd0);
    send_sample(3'd1, 12'd4000, 0, ttm_pkg::FAULT_NONE, 16'sd0);
    drain_outputs();

    betas = '{14'd3435, 14'd1000, 14'd10000, 14'd0, 14'd0, 14'd3950, 14'd1000, 14'd10000};
    fss   = '{12'd4095, 12'd4095, 12'd4095, 12'd2, 12'd0, 12'd1, 12'd3000, 12'd0};
    for (int p = 0; p < 8; p++) begin
      write_reg(ttm_pkg::REG_BETA,
                (betas[p] == 0) ? 14'($urandom_range(10000, 1000)) : betas[p]);
      write_reg(ttm_pkg::REG_FS,
                (fss[p] == 0) ? 14'($urandom_range(4095, 1)) : 14'(fss[p]));
      quiet_sender = (p == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 8) adc = 0;
        else if (pick < 16) adc = $urandom_range(4095, fs_q);
        else if (pick < 26 || fs_q < 2) adc = $urandom_range(4095);
        else adc = $urandom_range(fs_q - 1, 1);
        send_sample(3'($urandom_range(7)), 12'(adc), 0, ttm_pkg::FAULT_NONE, 16'sd0);
      end
      drain_outputs();
    end
    quiet_sender = 0;
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hdl/ttm_pkg.sv
hdl/ttm_ctrl.sv
hdl/ttm_dp.sv
hdl/thermistor_temperature_monitor.sv
tb/thermistor_temperature_monitor_tb.sv
